FILE: rtl/gpdf_pkg.sv
// ============================================================================
// gpdf_pkg
// Types, constants and per-stage datapath of the normal density/CDF evaluator.
// ============================================================================
package gpdf_pkg;

    localparam int FRAC_BITS = 16;

    // Register indexes of the configuration port
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MEAN      = 2'd0,
        REG_INV_SIGMA = 2'd1
    } cfg_reg_t;

    // Q30 constants
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [29:0] LN2_Q30     = 30'd744261118;
    localparam logic [28:0] INV_SQRT_2PI = 29'd428361012;
    localparam logic [27:0] P_Q30       = 28'd248723596;
    localparam logic [34:0] Z_CLAMP     = 35'h4_0000_0000;   // 16.0 in Q30
    localparam logic [10:0] K_RECIP     = 11'd1477;          // floor(2^40 / LN2_Q30)

    // Stage map
    localparam int ST_SUB    = 0;
    localparam int ST_MUL    = 1;
    localparam int ST_Z      = 2;
    localparam int ST_ZSQ    = 3;
    localparam int ST_E      = 4;
    localparam int ST_KEST   = 5;
    localparam int ST_KLN    = 6;
    localparam int ST_RSUB   = 7;
    localparam int ST_RFIX   = 8;
    localparam int EXP_TERMS = 12;
    localparam int ST_EXP    = 9;                         // three stages per term
    localparam int ST_MANT   = ST_EXP + 3 * EXP_TERMS;
    localparam int ST_MANTR  = ST_MANT + 1;
    localparam int ST_DENSM  = ST_MANT + 2;
    localparam int ST_DENS   = ST_MANT + 3;
    localparam int DIV_BITS  = 31;
    localparam int ST_DIV    = ST_DENS + 1;               // one quotient bit per stage
    localparam int ST_POLY   = ST_DIV + DIV_BITS;         // two stages per step
    localparam int POLY_STEPS = 5;
    localparam int ST_TAILM  = ST_POLY + 2 * POLY_STEPS;
    localparam int ST_TAIL   = ST_TAILM + 1;
    localparam int NSTAGE    = ST_TAIL + 1;

    typedef struct packed {
        logic               neg;
        logic [31:0]        x;
        logic [34:0]        z;
        logic [39:0]        ma;
        logic [34:0]        mb;
        logic [29:0]        mc;
        logic [45:0]        md;
        logic [44:0]        me;
        logic [37:0]        e;
        logic [32:0]        denom;
        logic [7:0]         k;
        logic [30:0]        rw;
        logic [29:0]        r;
        logic [30:0]        p;
        logic [63:0]        prod;
        logic [28:0]        mant;
        logic [31:0]        dens;
        logic [28:0]        phi;
        logic [33:0]        rem;
        logic [30:0]        q;
        logic signed [34:0] acc;
        logic               sg;
        logic [16:0]        cum;
    } pipe_t;

    // Round half up on a right shift
    function automatic logic [63:0] rshr64(input logic [63:0] v, input logic [7:0] s);
        logic [63:0] res;
        if (s == 8'd0)
            res = v;
        else if (s >= 8'd64)
            res = 64'd0;
        else
            res = (v >> s) + ((v >> (s - 8'd1)) & 64'd1);
        return res;
    endfunction

    // Exact divide of a value below 2^31 by i: (v * M) >> S
    function automatic logic [31:0] recip_m(input int i);
        logic [31:0] m;
        case (i)
            1:       m = 32'd2147483648;
            2:       m = 32'd2147483648;
            3:       m = 32'd2863311531;
            4:       m = 32'd2147483648;
            5:       m = 32'd3435973837;
            6:       m = 32'd2863311531;
            7:       m = 32'd2454267027;
            8:       m = 32'd2147483648;
            9:       m = 32'd3817748708;
            10:      m = 32'd3435973837;
            11:      m = 32'd3123612579;
            12:      m = 32'd2863311531;
            default: m = 32'd0;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] recip_s(input int i);
        logic [5:0] s;
        case (i)
            1:               s = 6'd31;
            2:               s = 6'd32;
            3, 4:            s = 6'd33;
            5, 6, 7, 8:      s = 6'd34;
            default:         s = 6'd35;
        endcase
        return s;
    endfunction

    function automatic logic [30:0] half_i(input int i);
        logic [30:0] h;
        case (i)
            2, 3:    h = 31'd1;
            4, 5:    h = 31'd2;
            6, 7:    h = 31'd3;
            8, 9:    h = 31'd4;
            10, 11:  h = 31'd5;
            12:      h = 31'd6;
            default: h = 31'd0;
        endcase
        return h;
    endfunction

    // Polynomial coefficient added after Horner step m
    function automatic logic signed [34:0] poly_coef(input int m);
        logic signed [34:0] c;
        case (m)
            0:       c = 35'sd1428371292 - 35'sd1428371292 - 35'sd1955558716;
            1:       c = 35'sd1912847369;
            2:       c = -35'sd382857446;
            3:       c = 35'sd342933307;
            default: c = 35'sd0;
        endcase
        return c;
    endfunction

    localparam logic signed [34:0] POLY_C4 = 35'sd1428371292;

    // One pipeline stage. j selects the operation; the other indexes are the
    // term, phase, quotient bit and polynomial step that belong to stage j.
    function automatic pipe_t stage_fn(
        input int          j,
        input int          ei,
        input int          eph,
        input int          db,
        input int          pm,
        input int          pph,
        input pipe_t       s,
        input logic [31:0] mean_v,
        input logic [31:0] isig
    );
        pipe_t              o;
        logic [32:0]        d;
        logic [32:0]        dmag;
        logic [63:0]        tmp;
        logic [19:0]        zh;
        logic [14:0]        zl;
        logic [37:0]        rdiff;
        logic [30:0]        qv;
        logic [34:0]        rr2;
        logic [33:0]        rr;
        logic [34:0]        mag;
        logic signed [34:0] val;
        logic [30:0]        tl;
        logic [30:0]        cdf;
        o = s;
        if (j == ST_SUB) begin
            d      = {s.x[31], s.x} - {mean_v[31], mean_v};
            dmag   = d[32] ? (~d + 33'd1) : d;
            o.neg  = d[32];
            o.prod = {32'd0, dmag[31:0]};
        end else if (j == ST_MUL) begin
            o.prod = 64'(s.prod[31:0]) * 64'(isig);
        end else if (j == ST_Z) begin
            if (s.prod >= (64'd16 << (2 * FRAC_BITS)))
                o.z = Z_CLAMP;
            else if (2 * FRAC_BITS >= 30) begin
                tmp = rshr64(s.prod, 8'(2 * FRAC_BITS - 30));
                o.z = tmp[34:0];
            end else begin
                tmp = s.prod << (30 - 2 * FRAC_BITS);
                o.z = tmp[34:0];
            end
        end else if (j == ST_ZSQ) begin
            zh   = s.z[34:15];
            zl   = s.z[14:0];
            o.ma = 40'(zh) * 40'(zh);
            o.mb = 35'(zh) * 35'(zl);
            o.mc = 30'(zl) * 30'(zl);
            o.md = 46'(s.z[34:17]) * 46'(P_Q30);
            o.me = 45'(s.z[16:0]) * 45'(P_Q30);
        end else if (j == ST_E) begin
            o.e     = 38'(s.ma >> 1) + 38'(s.mb >> 15) + 38'(s.mc >> 31);
            tmp     = (64'(s.md) << 17) + 64'(s.me);
            tmp     = rshr64(tmp, 8'd30);
            o.denom = 33'(ONE_Q30) + tmp[32:0];
        end else if (j == ST_KEST) begin
            o.prod = 64'(s.e[37:20]) * 64'(K_RECIP);
        end else if (j == ST_KLN) begin
            // estimate is k or k-1
            o.k    = s.prod[27:20];
            o.prod = 64'(s.prod[27:20]) * 64'(LN2_Q30);
        end else if (j == ST_RSUB) begin
            rdiff = s.e - s.prod[37:0];
            o.rw  = rdiff[30:0];
        end else if (j == ST_RFIX) begin
            if (s.rw >= 31'(LN2_Q30)) begin
                qv  = s.rw - 31'(LN2_Q30);
                o.r = qv[29:0];
                o.k = s.k + 8'd1;
            end else begin
                o.r = s.rw[29:0];
            end
            o.p = ONE_Q30;
        end else if (j >= ST_EXP && j < ST_MANT) begin
            // Horner term: p = 1 - rnd(r*p)/i, divide rounded half up
            if (eph == 0) begin
                o.prod = 64'(s.r) * 64'(s.p);
            end else if (eph == 1) begin
                tmp    = rshr64(s.prod, 8'd30);
                qv     = tmp[30:0] + half_i(ei);
                o.prod = 64'(qv) * 64'(recip_m(ei));
            end else begin
                tmp = s.prod >> recip_s(ei);
                o.p = ONE_Q30 - tmp[30:0];
            end
        end else if (j == ST_MANT) begin
            o.prod = 64'(s.p) * 64'(INV_SQRT_2PI);
        end else if (j == ST_MANTR) begin
            tmp    = rshr64(s.prod, 8'd30);
            o.mant = tmp[28:0];
        end else if (j == ST_DENSM) begin
            o.prod = 64'(s.mant) * 64'(isig);
            tmp    = rshr64(64'(s.mant), s.k);
            o.phi  = tmp[28:0];
        end else if (j == ST_DENS) begin
            tmp    = rshr64(s.prod, 8'd30 + s.k);
            o.dens = (tmp[63:32] != 32'd0) ? 32'hFFFF_FFFF : tmp[31:0];
        end else if (j >= ST_DIV && j < ST_POLY) begin
            // restoring divide of 2^60 + denom/2 by denom
            if (j == ST_DIV) begin
                rr    = 34'(ONE_Q30 >> 1) + 34'(s.denom[32]);
                o.acc = POLY_C4;
            end else begin
                rr = s.rem;
            end
            rr2 = {rr, s.denom[db + 1]};
            if (rr2 >= 35'(s.denom)) begin
                tmp     = 64'(rr2) - 64'(s.denom);
                o.rem   = tmp[33:0];
                o.q[db] = 1'b1;
            end else begin
                o.rem   = rr2[33:0];
                o.q[db] = 1'b0;
            end
        end else if (j >= ST_POLY && j < ST_TAILM) begin
            if (pph == 0) begin
                o.sg   = s.acc[34];
                mag    = s.acc[34] ? 35'(-s.acc) : 35'(s.acc);
                o.prod = 64'(mag[33:0]) * 64'(s.q);
            end else begin
                tmp = rshr64(s.prod, 8'd30);
                val = s.sg ? -$signed({1'b0, tmp[33:0]}) : $signed({1'b0, tmp[33:0]});
                if (pm < POLY_STEPS - 1)
                    o.acc = poly_coef(pm) + val;
                else
                    o.acc = val[34] ? 35'sd0 : val;
            end
        end else if (j == ST_TAILM) begin
            o.prod = 64'(s.phi) * 64'(s.acc[33:0]);
        end else if (j == ST_TAIL) begin
            tmp   = rshr64(s.prod, 8'd30);
            tl    = (tmp > 64'(ONE_Q30)) ? ONE_Q30 : tmp[30:0];
            cdf   = s.neg ? tl : (ONE_Q30 - tl);
            tmp   = rshr64(64'(cdf), 8'd14);
            o.cum = (tmp > 64'd65536) ? 17'd65536 : tmp[16:0];
        end
        return o;
    endfunction

endpackage

FILE: rtl/gaussian_pdf_cdf_evaluator_top.sv
// ============================================================================
// gaussian_pdf_cdf_evaluator_top
// Normal density and cumulative probability of a Q16.16 point, fully pipelined.
// ============================================================================
// Usage:
//   - Command channel: an item (x_value) is taken at a rising edge with start
//     high and busy low. busy never rises, so one item can enter every cycle.
//   - Result channel: density and cumulative are valid for the single cycle
//     in which done is high. The receiver cannot stall; results are never held.
//   - Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data.
//     Index 0 is mean (signed Q16.16), index 1 is inv_sigma (unsigned
//     Q16.16). cfg_ready is always high. Unknown indexes are dropped.
//     Write registers only while no items are in flight.
//   - Depth: 92 register stages (NSTAGE); done is the valid bit carried
//     through them. Throughput: one item per cycle.
//     The depth is set by the 12-term exp series (three stages per term,
//     two multipliers each) and the 31-stage restoring divider for t.
//   - Reset: rst_n clears the valid bits of every stage and loads mean = 0
//     and inv_sigma = 1.0. Payload registers are not reset.
// Datapath: z = |x-mean|*inv_sigma (Q30, clamped at 16), z^2/2 split into
//   k*ln2 + r, exp(-r) by Horner, phi and density by shifts of k, t by long
//   division, then the five-term tail polynomial and mirror for x < mean.
// ============================================================================
module gaussian_pdf_cdf_evaluator_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [31:0]             x_value,
    output logic                           done,
    output logic [31:0]                    density,
    output logic [16:0]                    cumulative,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gpdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);
    import gpdf_pkg::*;

    logic [31:0] mean_reg;
    logic [31:0] inv_sigma_reg;

    pipe_t       in_stage;
    pipe_t       pipe_next [0:NSTAGE-1];
    pipe_t       pipe_reg  [1:NSTAGE];
    logic        vld_reg   [1:NSTAGE];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg      <= 32'd0;
            inv_sigma_reg <= 32'd1 << FRAC_BITS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MEAN:      mean_reg      <= cfg_data;
                REG_INV_SIGMA: inv_sigma_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        in_stage   = '0;
        in_stage.x = x_value;
    end

    // Pipeline stages
    for (genvar j = 0; j < NSTAGE; j++)
    begin : g_stage
        localparam bit IN_EXP  = (j >= ST_EXP) && (j < ST_MANT);
        localparam bit IN_DIV  = (j >= ST_DIV) && (j < ST_POLY);
        localparam bit IN_POLY = (j >= ST_POLY) && (j < ST_TAILM);
        localparam int EI  = IN_EXP  ? EXP_TERMS - (j - ST_EXP) / 3 : 1;
        localparam int EPH = IN_EXP  ? (j - ST_EXP) % 3 : 0;
        localparam int DB  = IN_DIV  ? DIV_BITS - 1 - (j - ST_DIV) : 0;
        localparam int PM  = IN_POLY ? (j - ST_POLY) / 2 : 0;
        localparam int PPH = IN_POLY ? (j - ST_POLY) % 2 : 0;

        if (j == 0)
        begin : g_first
            always_comb
            begin
                pipe_next[j] = stage_fn(j, EI, EPH, DB, PM, PPH, in_stage,
                                        mean_reg, inv_sigma_reg);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[j+1] <= 1'b0;
                else
                    vld_reg[j+1] <= start && !busy;
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                pipe_next[j] = stage_fn(j, EI, EPH, DB, PM, PPH, pipe_reg[j],
                                        mean_reg, inv_sigma_reg);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[j+1] <= 1'b0;
                else
                    vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            pipe_reg[j+1] <= pipe_next[j];
        end
    end

    assign done       = vld_reg[NSTAGE];
    assign density    = pipe_reg[NSTAGE].dens;
    assign cumulative = pipe_reg[NSTAGE].cum;

    // Assertions
    a_cum_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cumulative <= 17'd65536))
        else $error("cumulative above one");

    a_r_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_RFIX+1] |-> (pipe_reg[ST_RFIX+1].r < LN2_Q30))
        else $error("range reduction left r >= ln2");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_POLY] |-> (pipe_reg[ST_POLY].rem < 34'(pipe_reg[ST_POLY].denom)))
        else $error("divider remainder not below divisor");

    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_POLY] |-> ((pipe_reg[ST_POLY].q <= ONE_Q30) &&
                              (pipe_reg[ST_POLY].q != 31'd0)))
        else $error("t outside (0, 1]");

    a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_MANT] |-> ((pipe_reg[ST_MANT].p <= ONE_Q30) &&
                              (pipe_reg[ST_MANT].p != 31'd0)))
        else $error("exp series outside (0, 1]");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Normal density / CDF evaluator testbench
// Drives x points through the command port under several mean and inv_sigma
// settings, with random sender gaps. A local fixed-point predictor computes
// each density and cumulative value, and the monitor checks every result in
// order against it.
// ----------------------------------------------------------------------------
module testbench;
    import gpdf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd2;   // index with no register
    localparam logic [CFG_IDX_W-1:0] REG_LAST   = 2'd3;
    localparam int DRAIN_CYCLES = 120;                    // past the 92-stage pipeline
    localparam int STALL_LIMIT  = 4000;

    localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
    localparam logic [63:0] Q30_LN2   = 64'd744261118;
    localparam logic [63:0] Q30_RSQ2P = 64'd428361012;
    localparam logic [63:0] Q30_P     = 64'd248723596;
    localparam logic [63:0] Q30_ZMAX  = 64'd16 << 30;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] x_value;
    logic        done;
    logic [31:0] density;
    logic [16:0] cumulative;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    typedef struct {
        logic [31:0] dens;
        logic [16:0] cum;
    } pdf_cdf_t;

    logic [31:0] pending_x[$];        // items waiting for the driver
    pdf_cdf_t    expected_pdf_cdf[$]; // predictions not yet seen on the outputs

    logic [31:0] model_mean;
    logic [31:0] model_isig;
    int          send_idle_pct;
    int          errors;
    int          n_sent;
    int          n_checked;
    int          n_cfg;
    int          quiet_cycles;

    gaussian_pdf_cdf_evaluator_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .x_value    (x_value),
        .done       (done),
        .density    (density),
        .cumulative (cumulative),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    // right shift, round half up; shifts of 64 or more give zero
    function automatic logic [63:0] shr_rnd(input logic [63:0] v, input int unsigned s);
        if (s == 0)
            return v;
        if (s >= 64)
            return 64'd0;
        return (v >> s) + ((v >> (s - 1)) & 64'd1);
    endfunction

    // signed Q30 product, rounding the magnitude
    function automatic longint mul_q30(input longint a, input logic [63:0] t);
        logic [63:0] mag;
        logic [63:0] r;
        mag = (a < 0) ? 64'(-a) : 64'(a);
        r   = shr_rnd(mag * t, 30);
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic pdf_cdf_t predict_pdf_cdf(input logic [31:0] x,
                                                 input logic [31:0] mu,
                                                 input logic [31:0] isig);
        longint      diff;
        logic        below;
        logic [63:0] mag, prod, z, zh, zl, e, k, r, p, q, mant, dens, phi;
        logic [63:0] denom, t, tail, cdf, cum;
        longint      acc;
        longint      coef[5];
        pdf_cdf_t    res;
        coef  = '{342933307, -382857446, 1912847369, -1955558716, 1428371292};
        diff  = longint'($signed(x)) - longint'($signed(mu));
        below = diff < 0;
        mag   = below ? 64'(-diff) : 64'(diff);
        prod  = mag * 64'(isig);
        if (prod >= (64'd16 << 32))
            z = Q30_ZMAX;
        else
            z = shr_rnd(prod, 2);
        if (z > Q30_ZMAX)
            z = Q30_ZMAX;

        // z^2/2 split into k*ln2 + r
        zh = z >> 15;
        zl = z & 64'h7FFF;
        e  = ((zh * zh) >> 1) + ((zh * zl) >> 15) + ((zl * zl) >> 31);
        k  = e / Q30_LN2;
        r  = e - k * Q30_LN2;

        // exp(-r), Horner from the 12th term down
        p = Q30_ONE;
        for (int i = 12; i >= 1; i--) begin
            q = shr_rnd(r * p, 30);
            p = Q30_ONE - (q + 64'(i / 2)) / 64'(i);
        end
        mant = shr_rnd(p * Q30_RSQ2P, 30);
        dens = shr_rnd(mant * 64'(isig), 30 + int'(k));
        if (dens > 64'hFFFF_FFFF)
            dens = 64'hFFFF_FFFF;
        phi = shr_rnd(mant, int'(k));

        // tail polynomial in t = 1/(1 + p|z|)
        denom = Q30_ONE + shr_rnd(Q30_P * z, 30);
        t     = ((64'd1 << 60) + denom / 2) / denom;
        acc   = coef[4];
        for (int j = 3; j >= 0; j--)
            acc = coef[j] + mul_q30(acc, t);
        acc = mul_q30(acc, t);
        if (acc < 0)
            acc = 0;
        tail = shr_rnd(phi * 64'(acc), 30);
        if (tail > Q30_ONE)
            tail = Q30_ONE;
        cdf = below ? tail : Q30_ONE - tail;
        cum = shr_rnd(cdf, 14);
        if (cum > 64'd65536)
            cum = 64'd65536;
        res.dens = dens[31:0];
        res.cum  = cum[16:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: takes items from pending_x, predicts each one as it is accepted
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            x_value <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_pdf_cdf.push_back(predict_pdf_cdf(x_value, model_mean, model_isig));
                void'(pending_x.pop_front());
                n_sent++;
            end
            // one assignment to start per edge, so a held start never glitches
            if (pending_x.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                start   <= 1'b1;
                x_value <= pending_x[0];
            end
            else
            begin
                start   <= 1'b0;
                x_value <= $urandom;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: one result per done strobe, checked against the oldest guess
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        pdf_cdf_t want;
        if (rst_n && done)
        begin
            n_checked++;
            if (expected_pdf_cdf.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result density=%h cumulative=%h",
                         $time, density, cumulative);
            end
            else
            begin
                want = expected_pdf_cdf.pop_front();
                if (density !== want.dens)
                begin
                    errors++;
                    $display("%0t: density expected %h actual %h", $time, want.dens, density);
                end
                if (cumulative !== want.cum)
                begin
                    errors++;
                    $display("%0t: cumulative expected %h actual %h",
                             $time, want.cum, cumulative);
                end
            end
        end
    end

    // Watchdog: any accepted item, result or register write resets the count
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    // register write; the model copy changes at the accepting edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_MEAN)
            model_mean = val;
        else if (idx == REG_INV_SIGMA)
            model_isig = val;
        n_cfg++;
        cfg_valid <= 1'b0;
        cfg_data  <= $urandom;
    endtask

    // wait until every queued item is in and every result is out
    task automatic drain();
        while (pending_x.size() > 0 || start || expected_pdf_cdf.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // points mostly within span of the mean, some anywhere
    task automatic queue_random(input int count, input int unsigned span);
        logic [31:0] off;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(9) < 2)
                pending_x.push_back($urandom);
            else
            begin
                off = $urandom_range(span);
                if ($urandom_range(1))
                    off = -off;
                pending_x.push_back(model_mean + off);
            end
        end
    endtask

    task automatic run_phase(input logic [31:0] mu, input logic [31:0] isig,
                             input int idle, input int count, input int unsigned span);
        drain();
        write_reg(REG_MEAN, mu);
        write_reg(REG_INV_SIGMA, isig);
        send_idle_pct = idle;
        queue_random(count, span);
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_MEAN;
        cfg_data      = '0;
        model_mean    = 32'd0;
        model_isig    = 32'd65536;
        send_idle_pct = 0;
        errors        = 0;
        n_sent        = 0;
        n_checked     = 0;
        n_cfg         = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed points at reset settings: mean, one LSB off, sigma steps,
        // far tails (z clamps at 16) and the extremes of x
        pending_x = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000,
                      32'hFFFF_0000, 32'h0002_0000, 32'hFFFE_0000, 32'h0003_8000,
                      32'h000F_FFFF, 32'h0010_0000, 32'hFFF0_0000, 32'h0040_0000,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA};

        // writes to unused indexes must change nothing
        drain();
        write_reg(REG_UNUSED, 32'hDEAD_BEEF);
        write_reg(REG_LAST, 32'h0000_0000);
        pending_x = '{32'h0000_8000, 32'hFFFF_8000};

        // zero inv_sigma: flat z = 0, density 0, cumulative one half
        run_phase(32'h0012_3456, 32'd0, 0, 6, 32'h7FFF_FFFF);
        // extremes of both registers
        run_phase(32'h8000_0000, 32'hFFFF_FFFF, 0, 20, 32'h0000_0100);
        run_phase(32'h7FFF_FFFF, 32'd1, 57, 40, 32'h7FFF_FFFF);
        pending_x.push_back(32'h8000_0000);

        // random phases, mixing idle rates
        run_phase(32'd0, 32'd65536, 0, 120, 32'h0005_0000);
        run_phase($urandom, 32'h0000_4000, 57, 110, 32'h0014_0000);
        run_phase($urandom, 32'h0004_0000, 7, 110, 32'h0001_8000);
        run_phase($urandom_range(32'h0010_0000), $urandom, 0, 90, 32'h0000_0400);
        run_phase(-$urandom_range(32'h0100_0000), $urandom_range(32'h0010_0000, 32'h100),
                  57, 110, 32'h0008_0000);
        run_phase($urandom, 32'h0001_0000 + $urandom_range(32'hFFFF), 7, 100,
                  32'h0006_0000);
        drain();

        $display("checked %0d results from %0d items over %0d register writes",
                 n_checked, n_sent, n_cfg);
        $display("covered zero and extreme inv_sigma, extreme means and clamped tails");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/gpdf_pkg.sv
rtl/gaussian_pdf_cdf_evaluator_top.sv
tb/testbench.sv
